// File: design/stepper_move_sequencer_defines.svh
// Assertion macros shared by the stepper sequencer RTL.
`ifndef STEPPER_MOVE_SEQUENCER_DEFINES_SVH
`define STEPPER_MOVE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper sequencer check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper sequencer check failed");

`endif

// File: design/sms_pkg.sv
`default_nettype none

package sms_pkg;

    localparam int POS_W   = 32;
    localparam int ROT_W   = 16;
    localparam int DELAY_W = 24;
    localparam int COIL_W  = 4;
    localparam int CFG_W   = 24;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -32'sh7FFF_FFFF;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd10000;
    localparam logic [ROT_W-1:0]   SPR_RESET   = 16'd200;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_MOVE_REL  = 3'd1,
        CMD_MOVE_HOME = 3'd2,
        CMD_SET_HOME  = 3'd3,
        CMD_MOVE_ZERO = 3'd4,
        CMD_SET_ZERO  = 3'd5
    } cmd_t;

    typedef enum logic {
        REG_STEP_DELAY = 1'b0,
        REG_STEPS_PER_ROT = 1'b1
    } cfg_idx_t;

    // Full-step coil drive for phase 0..3.
    function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] phase);
        logic [COIL_W-1:0] c;
        unique case (phase)
            2'd0: c = 4'hA;
            2'd1: c = 4'h6;
            2'd2: c = 4'h5;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/stepper_move_sequencer.sv
// A command beat is captured in the input register and then applied to the
// state/result registers, which present its result; a waiting result stalls it.
// Throughput: one command per cycle while results are taken; a result left
// waiting holds the next beat in the input register and stalls the input.
// Reset (rst_n low, asynchronous): position, rotation, remaining steps, wait
// count and coils clear, direction forward, delay 10000 ticks, 200 steps/rev.
`default_nettype none

`include "stepper_move_sequencer_defines.svh"

module stepper_move_sequencer
    import sms_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    // command channel
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [2:0]               command,
    input  wire  signed [POS_W-1:0]  step_count,
    // result channel
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [COIL_W-1:0]        coil_pattern,
    output logic signed [POS_W-1:0]  position,
    output logic [ROT_W-1:0]         rotation_step,
    output logic                     busy_res,
    output logic                     stepped,
    output logic                     rejected,
    // configuration write channel
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire  [0:0]               cfg_index,
    input  wire  [CFG_W-1:0]         cfg_data
);

    // Input register: one command beat waiting to be applied.
    logic                     in_full_reg;
    logic [2:0]               cmd_reg;
    logic signed [POS_W-1:0]  count_reg;

    // Configuration.
    logic [DELAY_W-1:0] delay_reg;
    logic [ROT_W-1:0]   spr_reg;

    // Motor state. These double as the result register: they only change
    // when a command is applied, which needs the result slot to be free.
    logic signed [POS_W-1:0] pos_reg,     pos_next;
    logic [ROT_W-1:0]        rot_reg,     rot_next;
    logic [POS_W-1:0]        remain_reg,  remain_next;
    logic                    fwd_reg,     fwd_next;
    logic [DELAY_W-1:0]      wait_reg,    wait_next;
    logic [COIL_W-1:0]       coil_reg,    coil_next;
    logic                    stepped_reg, stepped_next;
    logic                    rejected_reg, rejected_next;
    logic                    out_valid_reg;

    logic advance;

    // Apply the held command when the result slot is empty or being drained.
    assign advance   = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign coil_pattern  = coil_reg;
    assign position      = pos_reg;
    assign rotation_step = rot_reg;
    assign busy_res      = (remain_reg != '0);
    assign stepped       = stepped_reg;
    assign rejected      = rejected_reg;

    // ------------------------------------------------------------------
    // Command evaluation
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [ROT_W-1:0]  spr_eff;
        logic [ROT_W:0]    rot_inc;
        logic [ROT_W-1:0]  rot_step;
        logic [POS_W-1:0]  pos_mag;
        logic [POS_W-1:0]  cnt_mag;
        logic              busy;
        logic              is_move;

        spr_eff = (spr_reg == '0) ? ROT_W'(1) : spr_reg;
        busy    = (remain_reg != '0);
        is_move = (cmd_reg == CMD_MOVE_REL) || (cmd_reg == CMD_MOVE_HOME)
                  || (cmd_reg == CMD_MOVE_ZERO);

        // One step in the current direction; wrap the rotation at spr_eff.
        rot_inc = {1'b0, rot_reg} + (ROT_W+1)'(1);
        if (fwd_reg)
            rot_step = (rot_inc >= {1'b0, spr_eff}) ? '0 : rot_inc[ROT_W-1:0];
        else
            rot_step = (rot_reg == '0 || rot_reg >= spr_eff)
                       ? spr_eff - ROT_W'(1) : rot_reg - ROT_W'(1);

        pos_mag = pos_reg[POS_W-1] ? (POS_W'(0) - POS_W'(pos_reg)) : POS_W'(pos_reg);
        cnt_mag = count_reg[POS_W-1] ? (POS_W'(0) - POS_W'(count_reg))
                                     : POS_W'(count_reg);

        pos_next      = pos_reg;
        rot_next      = rot_reg;
        remain_next   = remain_reg;
        fwd_next      = fwd_reg;
        wait_next     = wait_reg;
        coil_next     = coil_reg;
        stepped_next  = 1'b0;
        rejected_next = 1'b0;

        if (is_move && busy)
        begin
            rejected_next = 1'b1;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_TICK:
                begin
                    if (busy)
                    begin
                        if (wait_reg >= delay_reg)
                        begin
                            wait_next    = '0;
                            stepped_next = 1'b1;
                            remain_next  = remain_reg - POS_W'(1);
                            rot_next     = rot_step;
                            coil_next    = coil_of(rot_step[1:0]);
                            if (fwd_reg)
                            begin
                                if (pos_reg != POS_MAX)
                                    pos_next = pos_reg + POS_W'(1);
                            end
                            else
                            begin
                                if (pos_reg != POS_MIN)
                                    pos_next = pos_reg - POS_W'(1);
                            end
                        end
                        else
                        begin
                            wait_next = wait_reg + DELAY_W'(1);
                        end
                    end
                end
                CMD_MOVE_REL:
                begin
                    remain_next = cnt_mag;
                    fwd_next    = !count_reg[POS_W-1];
                    wait_next   = '0;
                end
                CMD_MOVE_HOME:
                begin
                    remain_next = pos_mag;
                    fwd_next    = pos_reg[POS_W-1];
                    wait_next   = '0;
                end
                CMD_SET_HOME:
                begin
                    pos_next = '0;
                end
                CMD_MOVE_ZERO:
                begin
                    // Rotation at or above a lowered spr: one forward step wraps to zero.
                    if (rot_reg != '0)
                    begin
                        remain_next = (rot_reg < spr_eff)
                                      ? POS_W'(spr_eff - rot_reg) : POS_W'(1);
                        fwd_next    = 1'b1;
                        wait_next   = '0;
                    end
                end
                CMD_SET_ZERO:
                begin
                    rot_next = '0;
                end
                default:
                begin
                    // unknown commands: drop, state unchanged
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            delay_reg     <= DELAY_RESET;
            spr_reg       <= SPR_RESET;
            pos_reg       <= '0;
            rot_reg       <= '0;
            remain_reg    <= '0;
            fwd_reg       <= 1'b1;
            wait_reg      <= '0;
            coil_reg      <= '0;
            stepped_reg   <= 1'b0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            // hold the command beat until it is applied
            if (in_ready)
                in_full_reg <= in_valid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_STEP_DELAY:    delay_reg <= cfg_data[DELAY_W-1:0];
                    REG_STEPS_PER_ROT: spr_reg   <= cfg_data[ROT_W-1:0];
                    default:           delay_reg <= delay_reg;
                endcase
            end

            // advance the motor state and publish the result
            if (advance)
            begin
                pos_reg      <= pos_next;
                rot_reg      <= rot_next;
                remain_reg   <= remain_next;
                fwd_reg      <= fwd_next;
                wait_reg     <= wait_next;
                coil_reg     <= coil_next;
                stepped_reg  <= stepped_next;
                rejected_reg <= rejected_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            count_reg <= step_count;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SMS_ASSERT_IMP(a_step_drives_coils, out_valid_reg && stepped_reg, coil_reg != '0)
    `SMS_ASSERT_IMP(a_step_xor_reject, out_valid_reg, !(stepped_reg && rejected_reg))
    `SMS_ASSERT_IMP(a_pos_never_min, 1'b1, pos_reg != 32'sh8000_0000)
    `SMS_ASSERT_NXT(a_step_clears_wait, advance && stepped_next, wait_reg == '0)
    `SMS_ASSERT_NXT(a_reject_keeps_move, advance && rejected_next, $stable(remain_reg))

endmodule

`default_nettype wire
